/* rtl/sspl_pkg.sv */
`default_nettype none
package sspl_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SYM_W = 8;
  localparam int WT_W  = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic ins;          // place the incoming pair
    logic pop;          // emit the head entry and shift the row down
    logic drain_empty;  // emit the empty marker result
  } sspl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;        // no stored entries
    logic last_one;     // exactly one stored entry
  } sspl_stat_t;

endpackage
`default_nettype wire

/* rtl/stable_sorted_priority_list.sv */
// channel    handshake            payload
// input      start & !busy        in_cmd, in_symbol, in_weight
// result     out_valid (1 cycle)  out_symbol, out_weight, out_last,
//                                 out_empty_res, out_overflowed
//
// an insert does not raise busy: the row of compare-and-shift cells places the
// pair at once, so inserts may follow back to back
// a drain of n entries holds busy through its last pop, popping the head cell
// once a cycle; each result shows in the cycle after its pop, so the last one
// shows once busy is low again; a drain of an empty store does not raise busy
// and gives its marker result in the next cycle
// synchronous active-low reset empties the store and clears the overflow flag
// results cannot be stalled: each stays on the ports for one cycle only
`default_nettype none
module stable_sorted_priority_list
  import sspl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_cmd,
  input  wire logic [SYM_W-1:0] in_symbol,
  input  wire logic [WT_W-1:0]  in_weight,
  output logic                  out_valid,
  output logic [SYM_W-1:0]      out_symbol,
  output logic [WT_W-1:0]       out_weight,
  output logic                  out_last,
  output logic                  out_empty_res,
  output logic                  out_overflowed
);

  sspl_cmd_t  cmd;   // controller commands
  sspl_stat_t stat;  // store occupancy back to the controller

  // sequencer: idle or draining
  sspl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // cell row, occupancy count, overflow flag and result register
  sspl_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_symbol      (in_symbol),
    .in_weight      (in_weight),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_symbol     (out_symbol),
    .out_weight     (out_weight),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res),
    .out_overflowed (out_overflowed)
  );

  // a drain on an empty store gives one marker result next cycle
  a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_DRAIN && stat.empty)
      |=> (out_valid && out_empty_res && out_last))
    else $error("empty drain did not give its marker result");

  // a result that is not the last one is followed by another
  a_drain_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("drain stopped before its last result");

  // the controller is idle again once the last result shows
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("still busy on the last result");

  // a drain empties the store
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> stat.empty)
    else $error("store not empty after the last result");

endmodule
`default_nettype wire

/* rtl/sspl_ctrl.sv */
`default_nettype none
module sspl_ctrl
  import sspl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       in_cmd,
  input  wire sspl_stat_t stat,
  output sspl_cmd_t       cmd,
  output logic            busy
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   take;

  assign take = start && !busy_r;
  assign busy = busy_r;

  always_comb begin
    cmd.ins         = take && (in_cmd == CMD_INSERT);
    cmd.drain_empty = take && (in_cmd == CMD_DRAIN) && stat.empty;
    cmd.pop         = (state_r == ST_DRAIN);
  end

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    case (state_r)
      ST_IDLE: begin
        if (take && (in_cmd == CMD_DRAIN) && !stat.empty) begin
          state_nxt = ST_DRAIN;
          busy_nxt  = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (stat.last_one) begin
          state_nxt = ST_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/sspl_dpath.sv */
`default_nettype none
module sspl_dpath
  import sspl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sspl_cmd_t        cmd,
  input  wire logic [SYM_W-1:0] in_symbol,
  input  wire logic [WT_W-1:0]  in_weight,
  output sspl_stat_t            stat,
  output logic                  out_valid,
  output logic [SYM_W-1:0]      out_symbol,
  output logic [WT_W-1:0]       out_weight,
  output logic                  out_last,
  output logic                  out_empty_res,
  output logic                  out_overflowed
);

  logic [SYM_W-1:0] sym_r [DEPTH];
  logic [WT_W-1:0]  wt_r  [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             valid_r;
  logic [SYM_W-1:0] osym_r;
  logic [WT_W-1:0]  owt_r;
  logic             olast_r, oempty_r, oovf_r;

  logic [DEPTH-1:0] gt;
  logic             full;
  logic             do_ins;

  // cells holding a heavier entry than the new one move up
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (wt_r[i] > in_weight);
    end
  end

  assign full          = (count_r == CNT_W'(DEPTH));
  assign do_ins        = cmd.ins && !full;
  assign stat.empty    = (count_r == '0);
  assign stat.last_one = (count_r == CNT_W'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          sym_r[i] <= sym_r[(i > 0) ? i - 1 : 0];
          wt_r[i]  <= wt_r[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || CNT_W'(i) == count_r) begin
          sym_r[i] <= in_symbol;
          wt_r[i]  <= in_weight;
        end
      end else if (cmd.pop && i < DEPTH - 1) begin
        sym_r[i] <= sym_r[(i < DEPTH - 1) ? i + 1 : i];
        wt_r[i]  <= wt_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.pop || cmd.drain_empty;
      if (do_ins) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.pop) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.ins && full) begin
        ovf_r <= 1'b1;
      end else if (cmd.drain_empty || (cmd.pop && stat.last_one)) begin
        ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      osym_r   <= sym_r[0];
      owt_r    <= wt_r[0];
      olast_r  <= stat.last_one;
      oempty_r <= 1'b0;
      oovf_r   <= ovf_r;
    end else if (cmd.drain_empty) begin
      osym_r   <= '0;
      owt_r    <= '0;
      olast_r  <= 1'b1;
      oempty_r <= 1'b1;
      oovf_r   <= ovf_r;
    end
  end

  assign out_valid      = valid_r;
  assign out_symbol     = osym_r;
  assign out_weight     = owt_r;
  assign out_last       = olast_r;
  assign out_empty_res  = oempty_r;
  assign out_overflowed = oovf_r;

endmodule
`default_nettype wire
